>>> src/rdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_pkg
// Types, widths and register codes shared by the ray/disk intersection block.
// ----------------------------------------------------------------------------
package rdi_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int NRM_W   = 16;
  localparam int RAD_W   = 31;
  localparam int MIND_W  = 16;
  localparam int Q_W     = 31;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int NUM_W   = DIFF_W + NRM_W + 2;
  localparam int DEN_W   = COORD_W + NRM_W + 2;
  localparam int A_W     = NUM_W;
  localparam int SH      = Q_W - COORD_FRAC_BITS;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int P_W     = PROD_W - COORD_FRAC_BITS + 1;
  localparam int SQ_W    = 2 * RAD_W;
  localparam int SUM_W   = SQ_W + 2;

  typedef enum logic [2:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_CENTER_Z       = 3'd2,
    REG_PLANE_NORMAL_X = 3'd3,
    REG_PLANE_NORMAL_Y = 3'd4,
    REG_PLANE_NORMAL_Z = 3'd5,
    REG_RADIUS         = 3'd6,
    REG_MIN_DISTANCE   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                      hit;
    logic [Q_W-1:0]            distance_t;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic signed [NRM_W-1:0]   face_normal_x;
    logic signed [NRM_W-1:0]   face_normal_y;
    logic signed [NRM_W-1:0]   face_normal_z;
    logic                      normal_flipped;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic signed [NRM_W-1:0]   plane_normal_x;
    logic signed [NRM_W-1:0]   plane_normal_y;
    logic signed [NRM_W-1:0]   plane_normal_z;
    logic [RAD_W-1:0]          radius;
    logic [MIND_W-1:0]         min_distance;
  } cfg_t;

  typedef struct packed {
    ray_t                    ray;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } dot_t;

  typedef struct packed {
    ray_t             ray;
    logic             miss;
    logic             flip;
    logic             sat;
    logic [A_W-1:0]   a;
    logic [DEN_W-1:0] b;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_t;

endpackage

>>> src/rdi_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_dot
// Three-stage pipeline forming dot(center - origin, n) and dot(dir, n).
// ----------------------------------------------------------------------------
module rdi_dot import rdi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  ray_t ray,
  input  cfg_t cfg,
  output logic out_valid,
  output dot_t dot
);

  logic [2:0] v;
  ray_t ray1, ray2;
  logic signed [DIFF_W-1:0] dfx, dfy, dfz;
  logic signed [DIFF_W+NRM_W-1:0] pnx, pny, pnz;
  logic signed [COORD_W+NRM_W-1:0] pdx, pdy, pdz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1 <= ray;
      dfx  <= $signed({cfg.center_x[COORD_W-1], cfg.center_x})
            - $signed({ray.origin_x[COORD_W-1], ray.origin_x});
      dfy  <= $signed({cfg.center_y[COORD_W-1], cfg.center_y})
            - $signed({ray.origin_y[COORD_W-1], ray.origin_y});
      dfz  <= $signed({cfg.center_z[COORD_W-1], cfg.center_z})
            - $signed({ray.origin_z[COORD_W-1], ray.origin_z});
      ray2 <= ray1;
      pnx  <= dfx * $signed(cfg.plane_normal_x);
      pny  <= dfy * $signed(cfg.plane_normal_y);
      pnz  <= dfz * $signed(cfg.plane_normal_z);
      pdx  <= $signed(ray1.dir_x) * $signed(cfg.plane_normal_x);
      pdy  <= $signed(ray1.dir_y) * $signed(cfg.plane_normal_y);
      pdz  <= $signed(ray1.dir_z) * $signed(cfg.plane_normal_z);
      dot.ray <= ray2;
      dot.num <= NUM_W'(pnx) + NUM_W'(pny) + NUM_W'(pnz);
      dot.den <= DEN_W'(pdx) + DEN_W'(pdy) + DEN_W'(pdz);
    end
  end

  assign out_valid = v[2];

endmodule

>>> src/rdi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_div
// Sign handling and a pipelined restoring divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rdi_div import rdi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  dot_t dot,
  output logic out_valid,
  output div_t quo
);

  logic [Q_W+1:0] v;
  div_t st [0:Q_W+1];
  div_t st1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Q_W:0], in_valid};
    end
  end

  always_comb begin
    st1_next     = st[0];
    st1_next.sat = {{(DEN_W+SH-A_W){1'b0}}, st[0].a} >= {st[0].b, {SH{1'b0}}};
    st1_next.rem = DEN_W'(st[0].a >> SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].ray  <= dot.ray;
      st[0].miss <= (dot.num == '0) || (dot.den == '0)
                 || (dot.num[NUM_W-1] != dot.den[DEN_W-1]);
      st[0].flip <= !dot.den[DEN_W-1] && (dot.den != '0);
      st[0].sat  <= 1'b0;
      st[0].a    <= A_W'(dot.num[NUM_W-1] ? -dot.num : dot.num);
      st[0].b    <= DEN_W'(dot.den[DEN_W-1] ? -dot.den : dot.den);
      st[0].rem  <= '0;
      st[0].q    <= '0;
      st[1]      <= st1_next;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_bit
    localparam int K = Q_W - 1 - i;
    logic              nb;
    logic [DEN_W:0]    trial;
    logic              ge;
    div_t              nxt;

    if (K >= COORD_FRAC_BITS) begin : g_num
      assign nb = st[i+1].a[K-COORD_FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {st[i+1].rem, nb};
    assign ge    = trial >= {1'b0, st[i+1].b};

    always_comb begin
      nxt     = st[i+1];
      nxt.rem = DEN_W'(ge ? trial - {1'b0, st[i+1].b} : trial);
      nxt.q   = {st[i+1].q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+2] <= nxt;
      end
    end
  end

  assign out_valid = v[Q_W+1];
  assign quo       = st[Q_W+1];

endmodule

>>> src/rdi_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_hit
// Hit point, radius test and result formatting in five stages.
// ----------------------------------------------------------------------------
module rdi_hit import rdi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  div_t    quo,
  input  cfg_t    cfg,
  output logic    out_valid,
  output result_t result
);

  function automatic logic signed [NRM_W-1:0] neg_sat(input logic signed [NRM_W-1:0] n);
    logic signed [NRM_W-1:0] r;
    if (n == {1'b1, {(NRM_W-1){1'b0}}}) begin
      r = {1'b0, {(NRM_W-1){1'b1}}};
    end else begin
      r = -n;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [P_W-1:0] p);
    logic signed [COORD_W-1:0] r;
    if ((&p[P_W-1:COORD_W-1]) || !(|p[P_W-1:COORD_W-1])) begin
      r = p[COORD_W-1:0];
    end else begin
      r = {p[P_W-1], {(COORD_W-1){!p[P_W-1]}}};
    end
    return r;
  endfunction

  logic [4:0] v;

  logic [Q_W-1:0] qf;
  logic [Q_W-1:0] q1, q2, q3, q4;
  logic           miss1, miss2, miss3, miss4;
  logic           flip1, flip2, flip3, flip4;
  ray_t           ray1;
  logic signed [PROD_W-1:0] prx, pry, prz;
  logic signed [PROD_W-1:0] wx, wy, wz;
  logic signed [P_W-1:0]    px, py, pz;
  logic signed [P_W:0]      ddx, ddy, ddz;
  logic [P_W:0]             adx, ady, adz;
  logic [RAD_W-1:0]         ax, ay, az;
  logic [2:0]               outr3, outr4;
  logic signed [COORD_W-1:0] sx3, sy3, sz3, sx4, sy4, sz4;
  logic [SQ_W-1:0]          sqx, sqy, sqz, r2;
  logic [SUM_W-1:0]         sum;
  logic                     hit;
  result_t                  result_next;

  assign qf = quo.sat ? {Q_W{1'b1}} : quo.q;

  assign wx = (prx >>> COORD_FRAC_BITS) + PROD_W'($signed(ray1.origin_x));
  assign wy = (pry >>> COORD_FRAC_BITS) + PROD_W'($signed(ray1.origin_y));
  assign wz = (prz >>> COORD_FRAC_BITS) + PROD_W'($signed(ray1.origin_z));

  assign ddx = $signed(cfg.center_x) - px;
  assign ddy = $signed(cfg.center_y) - py;
  assign ddz = $signed(cfg.center_z) - pz;
  assign adx = ddx[P_W] ? (P_W+1)'(-ddx) : (P_W+1)'(ddx);
  assign ady = ddy[P_W] ? (P_W+1)'(-ddy) : (P_W+1)'(ddy);
  assign adz = ddz[P_W] ? (P_W+1)'(-ddz) : (P_W+1)'(ddz);

  assign sum = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
  assign hit = !miss4 && !(|outr4) && (sum < SUM_W'(r2));

  always_comb begin
    result_next = '0;
    if (hit) begin
      result_next.hit            = 1'b1;
      result_next.distance_t     = q4;
      result_next.hit_x          = sx4;
      result_next.hit_y          = sy4;
      result_next.hit_z          = sz4;
      result_next.face_normal_x  = flip4 ? neg_sat(cfg.plane_normal_x) : cfg.plane_normal_x;
      result_next.face_normal_y  = flip4 ? neg_sat(cfg.plane_normal_y) : cfg.plane_normal_y;
      result_next.face_normal_z  = flip4 ? neg_sat(cfg.plane_normal_z) : cfg.plane_normal_z;
      result_next.normal_flipped = flip4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1    <= qf;
      miss1 <= quo.miss || (qf <= Q_W'(cfg.min_distance));
      flip1 <= quo.flip;
      ray1  <= quo.ray;
      prx   <= $signed(quo.ray.dir_x) * $signed({1'b0, qf});
      pry   <= $signed(quo.ray.dir_y) * $signed({1'b0, qf});
      prz   <= $signed(quo.ray.dir_z) * $signed({1'b0, qf});

      q2    <= q1;
      miss2 <= miss1;
      flip2 <= flip1;
      px    <= wx[P_W-1:0];
      py    <= wy[P_W-1:0];
      pz    <= wz[P_W-1:0];

      q3    <= q2;
      miss3 <= miss2;
      flip3 <= flip2;
      ax    <= adx[RAD_W-1:0];
      ay    <= ady[RAD_W-1:0];
      az    <= adz[RAD_W-1:0];
      outr3 <= {adx >= (P_W+1)'(cfg.radius), ady >= (P_W+1)'(cfg.radius),
                adz >= (P_W+1)'(cfg.radius)};
      sx3   <= sat_coord(px);
      sy3   <= sat_coord(py);
      sz3   <= sat_coord(pz);

      q4    <= q3;
      miss4 <= miss3;
      flip4 <= flip3;
      outr4 <= outr3;
      sx4   <= sx3;
      sy4   <= sy3;
      sz4   <= sz3;
      sqx   <= ax * ax;
      sqy   <= ay * ay;
      sqz   <= az * az;
      r2    <= cfg.radius * cfg.radius;

      result <= result_next;
    end
  end

  assign out_valid = v[4];

endmodule

>>> src/ray_disk_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_disk_intersection
// Streams rays against one disk held in registers and returns one result per
// ray: hit flag, distance, hit point and the normal facing the ray.
// ----------------------------------------------------------------------------
//   channel  handshake               payload
//   ray      ray_valid/ray_ready     ray (origin, direction)
//   result   result_valid/ready      result (hit, t, point, normal, flip)
//   cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One ray is taken per cycle while the output is not stalled; each result
// passes 41 register stages: three dot-product stages, 33 divider stages
// (two setup stages, then one quotient bit each) and five hit-test stages.
// The whole pipeline advances together and holds while a result waits at
// the output. Reset clears the valid bits and loads the default disk;
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module ray_disk_intersection import rdi_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          ray_valid,
  output logic          ray_ready,
  input  ray_t          ray,
  output logic          result_valid,
  input  logic          result_ready,
  output result_t       result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  cfg_reg_t      cfg_index,
  input  logic [31:0]   cfg_data
);

  cfg_t cfg;
  logic en;
  logic dot_valid, div_valid;
  dot_t dot;
  div_t quo;

  assign en        = !result_valid || result_ready;
  assign ray_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x       <= '0;
      cfg.center_y       <= '0;
      cfg.center_z       <= '0;
      cfg.plane_normal_x <= '0;
      cfg.plane_normal_y <= NRM_W'(16384);
      cfg.plane_normal_z <= '0;
      cfg.radius         <= RAD_W'(1) << COORD_FRAC_BITS;
      cfg.min_distance   <= MIND_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:       cfg.center_x       <= cfg_data;
        REG_CENTER_Y:       cfg.center_y       <= cfg_data;
        REG_CENTER_Z:       cfg.center_z       <= cfg_data;
        REG_PLANE_NORMAL_X: cfg.plane_normal_x <= cfg_data[NRM_W-1:0];
        REG_PLANE_NORMAL_Y: cfg.plane_normal_y <= cfg_data[NRM_W-1:0];
        REG_PLANE_NORMAL_Z: cfg.plane_normal_z <= cfg_data[NRM_W-1:0];
        REG_RADIUS:         cfg.radius         <= cfg_data[RAD_W-1:0];
        REG_MIN_DISTANCE:   cfg.min_distance   <= cfg_data[MIND_W-1:0];
        default:            cfg.min_distance   <= cfg.min_distance;
      endcase
    end
  end

  rdi_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray_valid),
    .ray       (ray),
    .cfg       (cfg),
    .out_valid (dot_valid),
    .dot       (dot)
  );

  rdi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dot_valid),
    .dot       (dot),
    .out_valid (div_valid),
    .quo       (quo)
  );

  rdi_hit u_hit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .quo       (quo),
    .cfg       (cfg),
    .out_valid (result_valid),
    .result    (result)
  );

endmodule

>>> src/rdi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_checker
// Port-level checks for the ray/disk intersection block.
// ----------------------------------------------------------------------------
module rdi_checker import rdi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    ray_valid,
  input logic    ray_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> result == '0)
    else $error("miss result is not all zero");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |-> result.distance_t != '0)
    else $error("hit with zero distance");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> ray_ready)
    else $error("ray refused with empty output");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !ray_ready)
    else $error("ray taken while output stalled");

endmodule

bind ray_disk_intersection rdi_checker u_rdi_checker (.*);
